[rtl/core/heightfield_triangle_interpolator_core_macros.svh]
// assertion macros for the heightfield interpolator checker
`ifndef HEIGHTFIELD_TRIANGLE_INTERPOLATOR_CORE_MACROS_SVH
`define HEIGHTFIELD_TRIANGLE_INTERPOLATOR_CORE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define HTI_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define HTI_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/hti_pkg.sv]
// shared constants, types and codes of the heightfield triangle interpolator
`timescale 1ns / 1ps
`default_nettype none
package hti_pkg;

    localparam int GRID_CELLS    = 32;
    localparam int FRAC_BITS     = 8;
    localparam int VERTS_PER_ROW = GRID_CELLS + 1;
    localparam int STORE_DEPTH   = VERTS_PER_ROW * VERTS_PER_ROW;
    localparam int ADDR_W        = $clog2(STORE_DEPTH);
    localparam int CELL_W        = $clog2(GRID_CELLS);
    localparam int VTX_W         = $clog2(VERTS_PER_ROW);

    // field widths fixed by the interface
    localparam int POS_W    = 24;
    localparam int HEIGHT_W = 16;
    localparam int ORIGIN_W = 16;
    localparam int GRIDF_W  = 6;
    localparam int CELLO_W  = 5;

    // local position and its integer part
    localparam int LX_W    = ((POS_W > ORIGIN_W + FRAC_BITS) ? POS_W
                             : ORIGIN_W + FRAC_BITS) + 1;
    localparam int CELLF_W = LX_W - 1 - FRAC_BITS;

    // blend arithmetic
    localparam int W_W    = FRAC_BITS + 1;
    localparam int PROD_W = HEIGHT_W + W_W + 1;
    localparam int SUM_W  = PROD_W + 2;
    localparam int HALF   = 1 << (FRAC_BITS - 1);
    localparam logic [W_W-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

    // configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = ORIGIN_W;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 1'b1;

    // operation codes
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                       operation;
        logic [GRIDF_W-1:0]         grid_x;
        logic [GRIDF_W-1:0]         grid_z;
        logic signed [HEIGHT_W-1:0] height_in;
        logic signed [POS_W-1:0]    pos_x;
        logic signed [POS_W-1:0]    pos_z;
    } t_in_word;

    typedef struct packed {
        logic signed [HEIGHT_W-1:0] height_out;
        logic                       upper_triangle;
        logic                       out_of_range;
        logic [CELLO_W-1:0]         cell_x;
        logic [CELLO_W-1:0]         cell_z;
        logic signed [HEIGHT_W-1:0] corner1_height;
        logic signed [HEIGHT_W-1:0] corner2_height;
        logic signed [HEIGHT_W-1:0] corner3_height;
    } t_out_word;

    // where a query lands in the chunk
    typedef struct packed {
        logic                 oor;
        logic                 upper;
        logic [CELL_W-1:0]    cx;
        logic [CELL_W-1:0]    cz;
        logic [FRAC_BITS-1:0] tx;
        logic [FRAC_BITS-1:0] tz;
    } t_loc;

endpackage
`default_nettype wire

[rtl/core/hti_locate.sv]
// origin subtract, cell split, range check and triangle pick for one query
`timescale 1ns / 1ps
`default_nettype none
module hti_locate (
    input  wire logic signed [hti_pkg::POS_W-1:0]    i_pos_x,
    input  wire logic signed [hti_pkg::POS_W-1:0]    i_pos_z,
    input  wire logic signed [hti_pkg::ORIGIN_W-1:0] i_origin_x,
    input  wire logic signed [hti_pkg::ORIGIN_W-1:0] i_origin_z,
    output hti_pkg::t_loc                            o_loc
);

    logic signed [hti_pkg::LX_W-1:0]    lx;
    logic signed [hti_pkg::LX_W-1:0]    lz;
    logic [hti_pkg::CELLF_W-1:0]        cell_x_full;
    logic [hti_pkg::CELLF_W-1:0]        cell_z_full;
    logic [hti_pkg::FRAC_BITS-1:0]      tx;
    logic [hti_pkg::FRAC_BITS-1:0]      tz;
    logic [hti_pkg::W_W-1:0]            t_sum;
    logic                               oor;

    always_comb begin
        lx = hti_pkg::LX_W'(i_pos_x)
             - (hti_pkg::LX_W'(i_origin_x) <<< hti_pkg::FRAC_BITS);
        lz = hti_pkg::LX_W'(i_pos_z)
             - (hti_pkg::LX_W'(i_origin_z) <<< hti_pkg::FRAC_BITS);
        cell_x_full = lx[hti_pkg::LX_W-2:hti_pkg::FRAC_BITS];
        cell_z_full = lz[hti_pkg::LX_W-2:hti_pkg::FRAC_BITS];
        tx = lx[hti_pkg::FRAC_BITS-1:0];
        tz = lz[hti_pkg::FRAC_BITS-1:0];
        t_sum = {1'b0, tx} + {1'b0, tz};
        oor = lx[hti_pkg::LX_W-1] || lz[hti_pkg::LX_W-1]
              || (cell_x_full >= hti_pkg::CELLF_W'(hti_pkg::GRID_CELLS))
              || (cell_z_full >= hti_pkg::CELLF_W'(hti_pkg::GRID_CELLS));

        o_loc = '0;
        o_loc.oor = oor;
        if (!oor) begin
            o_loc.upper = (t_sum > hti_pkg::ONE);
            o_loc.cx    = cell_x_full[hti_pkg::CELL_W-1:0];
            o_loc.cz    = cell_z_full[hti_pkg::CELL_W-1:0];
            o_loc.tx    = tx;
            o_loc.tz    = tz;
        end
    end

endmodule
`default_nettype wire

[rtl/core/heightfield_triangle_interpolator_core.sv]
// top level: vertex height store and barycentric height query sequencer
//
// input channel: i_in_valid / o_in_stall carry one t_in_word. a word is taken
// at a rising edge with i_in_valid high and o_in_stall low. operation write
// stores height_in at vertex (grid_x, grid_z); query looks up pos_x / pos_z.
// output channel: o_out_valid / i_out_stall carry one t_out_word per input
// word, in order. writes and out-of-range queries give an all-zero word
// (out_of_range set for the latter).
// configuration: i_cfg_we writes i_cfg_data to origin_x or origin_z picked
// by i_cfg_index; use it only while the block is idle (not enforced).
// timing: one word is worked at a time. a write or out-of-range query goes
// through locate and sum; an in-range query through locate, the corner
// reads, multiply and sum. the next word is taken once the block is idle.
// the corner reads use the single port of the height store: the three
// triangle corners are read one per cycle.
// a stalled result sits in the output register; the block finishes the
// next word up to the sum step and waits there until the register frees up.
// reset: synchronous, active low; clears the sequencer, the output valid
// and the origin registers. the height store is not cleared: every vertex
// must be written before it is queried.
`timescale 1ns / 1ps
`default_nettype none
module heightfield_triangle_interpolator_core (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    output      logic                               o_in_stall,
    input  wire hti_pkg::t_in_word                  i_in_word,
    output      logic                               o_out_valid,
    input  wire logic                               i_out_stall,
    output      hti_pkg::t_out_word                 o_out_word,
    input  wire logic                               i_cfg_we,
    input  wire logic [hti_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hti_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    // sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_LOCATE = 3'd1;
    localparam logic [2:0] S_READ   = 3'd2;
    localparam logic [2:0] S_MUL    = 3'd3;
    localparam logic [2:0] S_SUM    = 3'd4;

    // corner read steps: first, second, third corner, then last capture
    localparam logic [1:0] RD_LAST = 2'd3;

    logic [2:0]                              r_state;
    logic [2:0]                              n_state;
    logic signed [hti_pkg::ORIGIN_W-1:0]     r_origin_x;
    logic signed [hti_pkg::ORIGIN_W-1:0]     r_origin_z;
    hti_pkg::t_in_word                       r_in;
    hti_pkg::t_loc                           r_loc;
    hti_pkg::t_loc                           loc;
    logic                                    r_zero;
    logic                                    r_oor;
    logic [1:0]                              r_cnt;
    logic signed [hti_pkg::HEIGHT_W-1:0]     r_h [3];
    logic signed [hti_pkg::PROD_W-1:0]       r_p [3];
    logic                                    r_out_valid;
    hti_pkg::t_out_word                      r_out;
    hti_pkg::t_out_word                      out_next;

    // height store, one port, registered read
    logic [hti_pkg::HEIGHT_W-1:0]            r_mem [hti_pkg::STORE_DEPTH];
    logic [hti_pkg::HEIGHT_W-1:0]            r_rdata;
    logic                                    mem_we;
    logic [hti_pkg::ADDR_W-1:0]              mem_waddr;
    logic                                    mem_re;
    logic [hti_pkg::ADDR_W-1:0]              mem_raddr;

    logic                                    in_accept;
    logic                                    wr_in_grid;
    logic                                    out_load;
    logic [hti_pkg::VTX_W-1:0]               rd_x;
    logic [hti_pkg::VTX_W-1:0]               rd_z;
    logic [hti_pkg::W_W-1:0]                 w [3];
    logic signed [hti_pkg::SUM_W-1:0]        sum;
    logic signed [hti_pkg::SUM_W-1:0]        rnd;
    logic signed [hti_pkg::HEIGHT_W-1:0]     height_sat;

    localparam logic signed [hti_pkg::SUM_W-1:0] H_MAX = hti_pkg::SUM_W'(32767);
    localparam logic signed [hti_pkg::SUM_W-1:0] H_MIN = -hti_pkg::SUM_W'(32768);

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;
    // output register frees when empty or taken this cycle
    assign out_load    = (r_state == S_SUM) && (!r_out_valid || !i_out_stall);

    hti_locate u_locate (
        .i_pos_x    (r_in.pos_x),
        .i_pos_z    (r_in.pos_z),
        .i_origin_x (r_origin_x),
        .i_origin_z (r_origin_z),
        .o_loc      (loc)
    );

    // origin registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_origin_x <= '0;
            r_origin_z <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hti_pkg::REG_ORIGIN_X: r_origin_x <= i_cfg_data;
                hti_pkg::REG_ORIGIN_Z: r_origin_z <= i_cfg_data;
            endcase
        end
    end

    // write side: vertex writes outside the grid are dropped
    always_comb begin
        wr_in_grid = (int'(r_in.grid_x) <= hti_pkg::GRID_CELLS)
                     && (int'(r_in.grid_z) <= hti_pkg::GRID_CELLS);
        mem_we     = (r_state == S_LOCATE) && (r_in.operation == hti_pkg::OP_WRITE)
                     && wr_in_grid;
        mem_waddr  = hti_pkg::ADDR_W'(r_in.grid_x)
                     + hti_pkg::ADDR_W'(r_in.grid_z)
                       * hti_pkg::ADDR_W'(hti_pkg::VERTS_PER_ROW);
    end

    // read side: lower triangle a,b,d; upper b,c,d
    always_comb begin
        rd_x = hti_pkg::VTX_W'(r_loc.cx);
        rd_z = hti_pkg::VTX_W'(r_loc.cz);
        unique case (r_cnt)
            2'd0: rd_x = rd_x + hti_pkg::VTX_W'(r_loc.upper);
            2'd1: begin
                rd_x = rd_x + hti_pkg::VTX_W'(1);
                rd_z = rd_z + hti_pkg::VTX_W'(r_loc.upper);
            end
            2'd2: rd_z = rd_z + hti_pkg::VTX_W'(1);
            default: ;
        endcase
        mem_re    = (r_state == S_READ) && (r_cnt != RD_LAST);
        mem_raddr = hti_pkg::ADDR_W'(rd_x)
                    + hti_pkg::ADDR_W'(rd_z) * hti_pkg::ADDR_W'(hti_pkg::VERTS_PER_ROW);
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_in.height_in;
        end
        if (mem_re) begin
            r_rdata <= r_mem[mem_raddr];
        end
    end

    // barycentric weights, all within 0..one
    always_comb begin
        if (r_loc.upper) begin
            w[0] = hti_pkg::ONE - {1'b0, r_loc.tz};
            w[1] = {1'b0, r_loc.tx} + {1'b0, r_loc.tz} - hti_pkg::ONE;
            w[2] = hti_pkg::ONE - {1'b0, r_loc.tx};
        end else begin
            w[0] = hti_pkg::ONE - {1'b0, r_loc.tx} - {1'b0, r_loc.tz};
            w[1] = {1'b0, r_loc.tx};
            w[2] = {1'b0, r_loc.tz};
        end
    end

    // weighted sum, round half up, saturate
    always_comb begin
        sum = hti_pkg::SUM_W'(r_p[0]) + hti_pkg::SUM_W'(r_p[1])
              + hti_pkg::SUM_W'(r_p[2]) + hti_pkg::SUM_W'(hti_pkg::HALF);
        rnd = sum >>> hti_pkg::FRAC_BITS;
        priority if (rnd > H_MAX) begin
            height_sat = 16'sh7fff;
        end else if (rnd < H_MIN) begin
            height_sat = -16'sh8000;
        end else begin
            height_sat = rnd[hti_pkg::HEIGHT_W-1:0];
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_accept) n_state = S_LOCATE;
            S_LOCATE: begin
                if ((r_in.operation == hti_pkg::OP_WRITE) || loc.oor) begin
                    n_state = S_SUM;
                end else begin
                    n_state = S_READ;
                end
            end
            S_READ:   if (r_cnt == RD_LAST) n_state = S_MUL;
            S_MUL:    n_state = S_SUM;
            S_SUM:    if (out_load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_READ) begin
                r_cnt <= r_cnt + 2'd1;
            end else begin
                r_cnt <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in <= i_in_word;
        end
        if (r_state == S_LOCATE) begin
            r_loc  <= loc;
            r_zero <= (r_in.operation == hti_pkg::OP_WRITE) || loc.oor;
            r_oor  <= (r_in.operation == hti_pkg::OP_QUERY) && loc.oor;
        end
        // read data lands in the cycle after its address
        if ((r_state == S_READ) && (r_cnt != 2'd0)) begin
            r_h[r_cnt - 2'd1] <= r_rdata;
        end
        if (r_state == S_MUL) begin
            for (int i = 0; i < 3; i++) begin
                r_p[i] <= r_h[i] * $signed({1'b0, w[i]});
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // result word: all zero for writes, only the flag for out-of-range queries
    always_comb begin
        out_next = '0;
        if (r_zero) begin
            out_next.out_of_range = r_oor;
        end else begin
            out_next.height_out     = height_sat;
            out_next.upper_triangle = r_loc.upper;
            out_next.cell_x         = hti_pkg::CELLO_W'(r_loc.cx);
            out_next.cell_z         = hti_pkg::CELLO_W'(r_loc.cz);
            out_next.corner1_height = r_h[0];
            out_next.corner2_height = r_h[1];
            out_next.corner3_height = r_h[2];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out <= out_next;
        end
    end

endmodule
`default_nettype wire

[rtl/core/hti_checker.sv]
// port-level checker for the heightfield interpolator, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
`include "heightfield_triangle_interpolator_core_macros.svh"
module hti_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           i_in_valid,
    input wire logic                           o_in_stall,
    input wire logic                           o_out_valid,
    input wire logic                           i_out_stall,
    input wire hti_pkg::t_out_word             o_out_word
);

    // a held result keeps its word
    `HTI_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_out_word), "stalled result changed")

    // one word at a time: the input closes right after an acceptance
    `HTI_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_in_valid && !o_in_stall, o_in_stall, "input open after acceptance")

    // out-of-range results carry no height, cell or corners
    `HTI_ASSERT_NOW(a_oor_zero, i_clk, i_rst_n, o_out_valid && o_out_word.out_of_range, (o_out_word.height_out == '0) && !o_out_word.upper_triangle && (o_out_word.cell_x == '0) && (o_out_word.cell_z == '0) && (o_out_word.corner1_height == '0) && (o_out_word.corner2_height == '0) && (o_out_word.corner3_height == '0), "out-of-range result not cleared")

    // upper triangle results are never flagged out of range
    `HTI_ASSERT_NOW(a_upper_in_range, i_clk, i_rst_n, o_out_valid && o_out_word.upper_triangle, !o_out_word.out_of_range, "upper triangle flagged out of range")

endmodule

bind heightfield_triangle_interpolator_core hti_checker u_hti_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_word  (o_out_word)
);
`default_nettype wire

[test/heightfield_triangle_interpolator_core_checker.sv]
// result predictor and word-by-word comparator for the heightfield interpolator
`timescale 1ns / 1ps
module heightfield_triangle_interpolator_core_checker (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_in_valid,
    input  wire logic                               i_in_stall,
    input  wire hti_pkg::t_in_word                  i_in_word,
    input  wire logic                               i_out_valid,
    input  wire logic                               i_out_stall,
    input  wire hti_pkg::t_out_word                 i_out_word,
    input  wire logic                               i_cfg_we,
    input  wire logic [hti_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [hti_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                      o_results,
    output int                                      o_errors
);
    import hti_pkg::*;

    localparam longint ONE_Q     = longint'(1) << FRAC_BITS;
    localparam longint FRAC_MASK = ONE_Q - 1;

    // own copy of the vertex heights, indexed [z][x]
    logic signed [HEIGHT_W-1:0] vtx_height [VERTS_PER_ROW][VERTS_PER_ROW];
    logic signed [ORIGIN_W-1:0] org_x;
    logic signed [ORIGIN_W-1:0] org_z;
    t_out_word                  height_answers [$];
    int                         results_seen;
    int                         mismatches;

    task automatic report_error(input string what);
        $display("%0t checker: %s", $time, what);
        mismatches++;
    endtask

    task automatic check_field(input string name, input logic [HEIGHT_W-1:0] got,
                               input logic [HEIGHT_W-1:0] want);
        if (got !== want)
            report_error($sformatf("word %0d %s: got %h, expected %h",
                                   results_seen, name, got, want));
    endtask

    // applies one input word to the local store and returns the word it should give
    function automatic t_out_word interpolate_word(input t_in_word w);
        t_out_word r;
        longint    lx, lz, cx, cz, tx, tz;
        longint    h1, h2, h3, w1, w2, w3, acc;
        logic      up;
        r = '0;
        if (w.operation == OP_WRITE) begin
            if (w.grid_x <= GRID_CELLS && w.grid_z <= GRID_CELLS)
                vtx_height[w.grid_z][w.grid_x] = w.height_in;
            return r;
        end
        lx = longint'($signed(w.pos_x)) - longint'(org_x) * ONE_Q;
        lz = longint'($signed(w.pos_z)) - longint'(org_z) * ONE_Q;
        if (lx < 0 || lz < 0 || (lx >>> FRAC_BITS) >= GRID_CELLS
                || (lz >>> FRAC_BITS) >= GRID_CELLS) begin
            r.out_of_range = 1'b1;
            return r;
        end
        cx = lx >>> FRAC_BITS;
        cz = lz >>> FRAC_BITS;
        tx = lx & FRAC_MASK;
        tz = lz & FRAC_MASK;
        up = (tx + tz) > ONE_Q;
        if (!up) begin
            h1 = vtx_height[cz][cx];
            h2 = vtx_height[cz][cx+1];
            h3 = vtx_height[cz+1][cx];
            w1 = ONE_Q - tx - tz;
            w2 = tx;
            w3 = tz;
        end else begin
            h1 = vtx_height[cz][cx+1];
            h2 = vtx_height[cz+1][cx+1];
            h3 = vtx_height[cz+1][cx];
            w1 = ONE_Q - tz;
            w2 = tx + tz - ONE_Q;
            w3 = ONE_Q - tx;
        end
        // round half up, arithmetic shift is a floor
        acc = (w1 * h1 + w2 * h2 + w3 * h3 + (ONE_Q >>> 1)) >>> FRAC_BITS;
        if (acc > 32767)
            acc = 32767;
        if (acc < -32768)
            acc = -32768;
        r.height_out     = acc[HEIGHT_W-1:0];
        r.upper_triangle = up;
        r.cell_x         = cx[CELLO_W-1:0];
        r.cell_z         = cz[CELLO_W-1:0];
        r.corner1_height = h1[HEIGHT_W-1:0];
        r.corner2_height = h2[HEIGHT_W-1:0];
        r.corner3_height = h3[HEIGHT_W-1:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            org_x = '0;
            org_z = '0;
            height_answers.delete();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == REG_ORIGIN_X)
                    org_x = i_cfg_data;
                else if (i_cfg_index == REG_ORIGIN_Z)
                    org_z = i_cfg_data;
            end
            if (i_in_valid && !i_in_stall)
                height_answers = {height_answers, interpolate_word(i_in_word)};
            if (i_out_valid && !i_out_stall) begin
                results_seen++;
                if (height_answers.size() == 0) begin
                    report_error($sformatf("word %0d arrived with none expected: %h",
                                           results_seen, i_out_word));
                end else begin
                    want = height_answers.pop_front();
                    check_field("height_out", i_out_word.height_out, want.height_out);
                    check_field("upper_triangle", HEIGHT_W'(i_out_word.upper_triangle),
                                HEIGHT_W'(want.upper_triangle));
                    check_field("out_of_range", HEIGHT_W'(i_out_word.out_of_range),
                                HEIGHT_W'(want.out_of_range));
                    check_field("cell_x", HEIGHT_W'(i_out_word.cell_x),
                                HEIGHT_W'(want.cell_x));
                    check_field("cell_z", HEIGHT_W'(i_out_word.cell_z),
                                HEIGHT_W'(want.cell_z));
                    check_field("corner1_height", i_out_word.corner1_height,
                                want.corner1_height);
                    check_field("corner2_height", i_out_word.corner2_height,
                                want.corner2_height);
                    check_field("corner3_height", i_out_word.corner3_height,
                                want.corner3_height);
                end
            end
        end
        // counts leave through nonblocking updates so the stimulus side reads them race free
        o_results <= results_seen;
        o_errors  <= mismatches;
    end

endmodule

[test/heightfield_triangle_interpolator_core_tb.sv]
// stimulus and verdict for the heightfield triangle interpolator core
`timescale 1ns / 1ps
module heightfield_triangle_interpolator_core_tb;
    import hti_pkg::*;

    localparam int ONE_I          = 1 << FRAC_BITS;
    localparam int FRAC_MAX       = ONE_I - 1;
    localparam int POS_MAX        = (1 << POS_W) - 1;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AT_WORD   = 450;
    localparam int LATENCY_PAD    = 12;
    localparam int WATCHDOG_LIMIT = 3000;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_word               i_in_word;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_word              o_out_word;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;

    int                     n_results;
    int                     n_errors;
    int                     n_sent;
    int                     idle_cycles = 0;
    logic                   hold_req;
    // which vertices hold a known height, indexed [z][x]
    logic                   vertex_set [VERTS_PER_ROW][VERTS_PER_ROW];
    logic signed [ORIGIN_W-1:0] cur_org_x;
    logic signed [ORIGIN_W-1:0] cur_org_z;

    always #6 i_clk = ~i_clk;

    heightfield_triangle_interpolator_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    heightfield_triangle_interpolator_core_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .i_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_results   (n_results),
        .o_errors    (n_errors)
    );

    // watchdog: ends the run after too many cycles with no word moving on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("heightfield_triangle_interpolator_core_tb: done, errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // result side: random stall, a calm window, and one long hold-off on request
    initial begin
        int cyc;
        bit held;
        cyc  = 0;
        held = 1'b0;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            cyc++;
            if (hold_req && !held) begin
                // hold long enough for the block to back up into its input
                held = 1'b1;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                cyc += HOLD_CYCLES;
            end else if (cyc >= 1200 && cyc < 2400) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(0, 99) < 15);
            end
        end
    end

    // offers one word, sometimes after a short gap, and waits until it is taken
    task automatic send_word(input t_in_word w);
        if (!(n_sent >= 250 && n_sent < 400) && $urandom_range(0, 99) < 15) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        n_sent++;
    endtask

    // unused fields carry noise so every input bit toggles
    task automatic send_write(input int gx, input int gz, input int h);
        t_in_word w;
        w.operation = OP_WRITE;
        w.grid_x    = gx[GRIDF_W-1:0];
        w.grid_z    = gz[GRIDF_W-1:0];
        w.height_in = h[HEIGHT_W-1:0];
        w.pos_x     = $urandom_range(0, POS_MAX);
        w.pos_z     = $urandom_range(0, POS_MAX);
        if (gx <= GRID_CELLS && gz <= GRID_CELLS)
            vertex_set[gz][gx] = 1'b1;
        send_word(w);
    endtask

    // a query that lands in the grid first gets any missing corner of its quad written
    task automatic send_query(input logic [POS_W-1:0] px, input logic [POS_W-1:0] pz);
        longint   lx, lz;
        int       cx, cz;
        t_in_word w;
        lx = longint'($signed(px)) - longint'(cur_org_x) * ONE_I;
        lz = longint'($signed(pz)) - longint'(cur_org_z) * ONE_I;
        if (lx >= 0 && lz >= 0 && (lx >>> FRAC_BITS) < GRID_CELLS
                && (lz >>> FRAC_BITS) < GRID_CELLS) begin
            cx = int'(lx >>> FRAC_BITS);
            cz = int'(lz >>> FRAC_BITS);
            for (int dz = 0; dz < 2; dz++)
                for (int dx = 0; dx < 2; dx++)
                    if (!vertex_set[cz+dz][cx+dx])
                        send_write(cx + dx, cz + dz, $urandom_range(0, 65535));
        end
        w.operation = OP_QUERY;
        w.grid_x    = $urandom_range(0, 63);
        w.grid_z    = $urandom_range(0, 63);
        w.height_in = $urandom_range(0, 65535);
        w.pos_x     = px;
        w.pos_z     = pz;
        send_word(w);
    endtask

    // world position of a quad index plus fraction under the given origin, wrapped to 24 bits
    function automatic logic [POS_W-1:0] place(input int idx, input int frac,
                                               input logic signed [ORIGIN_W-1:0] org);
        longint p;
        p = longint'(org) * ONE_I + longint'(idx) * ONE_I + frac;
        return p[POS_W-1:0];
    endfunction

    // favors the grid corners, where the edge vertices live
    function automatic int pick_index();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return $urandom_range(0, 3);
        if (r < 60)
            return $urandom_range(GRID_CELLS - 4, GRID_CELLS - 1);
        return $urandom_range(0, GRID_CELLS - 1);
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        @(posedge i_clk);
    endtask

    // stop offering and wait for every result, plus a few cycles of margin
    task automatic drain_results();
        i_in_valid <= 1'b0;
        while (n_results != n_sent)
            @(posedge i_clk);
        repeat (LATENCY_PAD) @(posedge i_clk);
    endtask

    task automatic set_origin(input logic signed [ORIGIN_W-1:0] ox,
                              input logic signed [ORIGIN_W-1:0] oz);
        drain_results();
        write_reg(REG_ORIGIN_X, ox);
        write_reg(REG_ORIGIN_Z, oz);
        cur_org_x = ox;
        cur_org_z = oz;
    endtask

    task automatic directed_checks();
        // one quad at full-scale heights of both signs
        send_write(0, 0, 16'h7FFF);
        send_write(1, 0, 16'h8000);
        send_write(0, 1, 1);
        send_write(1, 1, 16'hFFFF);
        send_query(place(0, 0, cur_org_x), place(0, 0, cur_org_z));
        // on the diagonal stays lower, one step past it goes upper
        send_query(place(0, ONE_I / 2, cur_org_x), place(0, ONE_I / 2, cur_org_z));
        send_query(place(0, ONE_I / 2 + 1, cur_org_x), place(0, ONE_I / 2, cur_org_z));
        send_query(place(0, FRAC_MAX, cur_org_x), place(0, FRAC_MAX, cur_org_z));
        send_query(place(0, FRAC_MAX, cur_org_x), place(0, 0, cur_org_z));
        send_query(place(0, 0, cur_org_x), place(0, FRAC_MAX, cur_org_z));
        // writes past the grid edge are dropped
        send_write(GRID_CELLS + 1, 0, 16'h1234);
        send_write(0, GRID_CELLS + 1, 16'h4321);
        send_write(63, 63, 16'h5555);
        // just below the origin and just past the last quad
        send_query(place(-1, FRAC_MAX, cur_org_x), place(0, 0, cur_org_z));
        send_query(place(0, 0, cur_org_x), place(-1, FRAC_MAX, cur_org_z));
        send_query(place(GRID_CELLS, 0, cur_org_x), place(0, 0, cur_org_z));
        send_query(place(0, 0, cur_org_x), place(GRID_CELLS, 0, cur_org_z));
        // extremes of the position fields
        send_query(24'h7FFFFF, 24'h800000);
        send_query(24'h800000, 24'h7FFFFF);
        // far corner quad, which uses the last vertex row and column
        send_query(place(GRID_CELLS - 1, FRAC_MAX, cur_org_x),
                   place(GRID_CELLS - 1, FRAC_MAX, cur_org_z));
        send_query(place(GRID_CELLS - 1, 0, cur_org_x),
                   place(GRID_CELLS - 1, FRAC_MAX, cur_org_z));
    endtask

    task automatic random_item();
        int pick, cx, cz, tx, tz, edge_idx;
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            // well-formed query into the grid, often on or near the diagonal
            cx = pick_index();
            cz = pick_index();
            tx = $urandom_range(0, FRAC_MAX);
            case ($urandom_range(0, 9))
                0, 1: tz = (ONE_I - tx) & FRAC_MAX;
                2:    tz = (ONE_I + 1 - tx) & FRAC_MAX;
                3:    tz = FRAC_MAX;
                default: tz = $urandom_range(0, FRAC_MAX);
            endcase
            send_query(place(cx, tx, cur_org_x), place(cz, tz, cur_org_z));
        end else if (pick < 75) begin
            send_write($urandom_range(0, GRID_CELLS), $urandom_range(0, GRID_CELLS),
                       $urandom_range(0, 65535));
        end else if (pick < 80) begin
            if ($urandom_range(0, 1))
                send_write($urandom_range(GRID_CELLS + 1, 63), $urandom_range(0, 63),
                           $urandom_range(0, 65535));
            else
                send_write($urandom_range(0, 63), $urandom_range(GRID_CELLS + 1, 63),
                           $urandom_range(0, 65535));
        end else if (pick < 95) begin
            send_query($urandom_range(0, POS_MAX), $urandom_range(0, POS_MAX));
        end else begin
            // one axis just outside the grid, the other inside
            edge_idx = $urandom_range(0, 1) ? -1 : GRID_CELLS;
            if ($urandom_range(0, 1))
                send_query(place(edge_idx, $urandom_range(0, FRAC_MAX), cur_org_x),
                           place(pick_index(), $urandom_range(0, FRAC_MAX), cur_org_z));
            else
                send_query(place(pick_index(), $urandom_range(0, FRAC_MAX), cur_org_x),
                           place(edge_idx, $urandom_range(0, FRAC_MAX), cur_org_z));
        end
    endtask

    task automatic run_phase(input logic signed [ORIGIN_W-1:0] ox,
                             input logic signed [ORIGIN_W-1:0] oz, input int count);
        int target;
        set_origin(ox, oz);
        target = n_sent + count;
        while (n_sent < target) begin
            if (n_sent >= HOLD_AT_WORD)
                hold_req <= 1'b1;
            random_item();
        end
    endtask

    initial begin
        int r;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_ORIGIN_X;
        i_cfg_data  = '0;
        hold_req    = 1'b0;
        n_sent      = 0;
        cur_org_x   = '0;
        cur_org_z   = '0;
        for (int z = 0; z < VERTS_PER_ROW; z++)
            for (int x = 0; x < VERTS_PER_ROW; x++)
                vertex_set[z][x] = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        set_origin(16'sd0, 16'sd0);
        directed_checks();

        // origins at both extremes; at the positive end only quad 0 fits in 24 bits
        run_phase(16'sh8000, 16'sh8000, 150);
        run_phase(16'sh7FFF, 16'sh7FFF, 60);
        run_phase(-16'sd7, 16'sd19, 220);
        r = int'($urandom_range(0, 200)) - 100;
        run_phase(r[ORIGIN_W-1:0], 16'sd3, 180);
        run_phase(16'sh7FFF, 16'sh8000, 60);
        run_phase(16'sd0, 16'sd0, 250);

        drain_results();
        if (n_errors == 0)
            $display("heightfield_triangle_interpolator_core_tb: done, clean");
        else
            $display("heightfield_triangle_interpolator_core_tb: done, errors");
        $finish;
    end

endmodule
